// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the circular queue controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge out of reset.
`define CQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next one.
`define CQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cqs_pkg.sv -----
// ----------------------------------------------------------------------------
// cqs_pkg
// Sizes, codes, types and helper functions of the circular queue.
// ----------------------------------------------------------------------------
package cqs_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned MAX_RES = 16;
  localparam int unsigned SLOT_W  = $clog2(DEPTH);
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CAP_LIM = (DEPTH < MAX_RES) ? DEPTH : MAX_RES;
  localparam int unsigned NXT_W   = (SLOT_W + 1 > CAP_W) ? SLOT_W + 1 : CAP_W;

  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [CAP_W-1:0]         cap_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [POS_W-1:0]         pos_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2,
    OP_SEARCH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_RESULT = 2'd1,
    S_WALK   = 2'd2
  } state_e;

  typedef struct packed {
    status_e status;
    data_t   data;
    pos_t    position;
    logic    last;
  } res_t;

  typedef struct packed {
    logic  we;
    slot_t waddr;
    data_t wdata;
    logic  re;
    slot_t raddr;
  } ram_req_t;

  // Slot after s in a ring of cap slots.
  function automatic slot_t next_slot(slot_t s, cap_t cap);
    logic [NXT_W-1:0] inc;
    inc = NXT_W'(s) + NXT_W'(1);
    return (inc >= NXT_W'(cap)) ? '0 : SLOT_W'(inc);
  endfunction

  // Clamp a written capacity to 1 .. CAP_LIM.
  function automatic cap_t eff_cap(cap_t raw);
    cap_t c;
    c = raw;
    if (c == '0) begin
      c = CAP_W'(1);
    end else if (c > CAP_W'(CAP_LIM)) begin
      c = CAP_W'(CAP_LIM);
    end
    return c;
  endfunction

endpackage

// ----- hdl/cqs_if.sv -----
// ----------------------------------------------------------------------------
// Circular queue channels
// Valid/ready channels for commands, results and the capacity write.
// ----------------------------------------------------------------------------
interface cqs_in_if;
  logic               valid;
  logic               ready;
  cqs_pkg::op_e       opcode;
  cqs_pkg::data_t     value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface cqs_out_if;
  logic               valid;
  logic               ready;
  cqs_pkg::status_e   status;
  cqs_pkg::data_t     data;
  cqs_pkg::pos_t      position;
  logic               last;

  modport source (output valid, output status, output data, output position,
                  output last, input ready);
  modport sink (input valid, input status, input data, input position,
                input last, output ready);
endinterface

interface cqs_cfg_if;
  logic               valid;
  logic               ready;
  cqs_pkg::cap_t      data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/cqs_ram.sv -----
// ----------------------------------------------------------------------------
// cqs_ram
// Generic memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/cqs_ctrl.sv -----
// ----------------------------------------------------------------------------
// cqs_ctrl
// Sequencer of the queue: pointers, insert, and the slot walk that removes,
// lists or searches the stored elements one memory read per cycle, holding on a stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cqs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  cqs_pkg::cap_t     cap_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cqs_pkg::op_e      in_op_i,
  input  cqs_pkg::data_t    in_value_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output cqs_pkg::res_t     res_o,
  output cqs_pkg::ram_req_t ram_req_o,
  input  cqs_pkg::data_t    ram_rdata_i
);

  cqs_pkg::state_e  state_q, state_d;
  cqs_pkg::slot_t   head_q, head_d;
  cqs_pkg::slot_t   tail_q, tail_d;
  logic             empty_q, empty_d;
  cqs_pkg::slot_t   s_q, s_d;
  cqs_pkg::cap_t    n_q, n_d;
  cqs_pkg::op_e     op_q, op_d;
  cqs_pkg::data_t   value_q, value_d;
  cqs_pkg::status_e status_q, status_d;

  cqs_pkg::slot_t   head_nxt, tail_nxt, s_nxt;
  logic             fin, match, emit, res_last, advance;

  assign head_nxt = cqs_pkg::next_slot(head_q, cap_i);
  assign tail_nxt = cqs_pkg::next_slot(tail_q, cap_i);
  assign s_nxt    = cqs_pkg::next_slot(s_q, cap_i);

  // Shared walk compare: end of the stored run, and value match.
  assign fin   = (s_q == tail_q) || ((n_q + cqs_pkg::CAP_W'(1)) == cap_i);
  assign match = (ram_rdata_i == value_q);

  assign emit     = (op_q != cqs_pkg::OP_SEARCH) || match || fin;
  assign res_last = (op_q == cqs_pkg::OP_LIST) ? fin : 1'b1;
  assign advance  = !emit || (res_ready_i && !res_last);

  always_comb begin : next_state
    state_d = state_q;
    unique case (state_q)
      cqs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if ((in_op_i == cqs_pkg::OP_INSERT) || empty_q) begin
            state_d = cqs_pkg::S_RESULT;
          end else begin
            state_d = cqs_pkg::S_WALK;
          end
        end
      end
      cqs_pkg::S_RESULT: begin
        if (res_ready_i) begin
          state_d = cqs_pkg::S_IDLE;
        end
      end
      cqs_pkg::S_WALK: begin
        if (emit && res_ready_i && res_last) begin
          state_d = cqs_pkg::S_IDLE;
        end
      end
      default: state_d = cqs_pkg::S_IDLE;
    endcase
  end

  always_comb begin : outputs
    head_d      = head_q;
    tail_d      = tail_q;
    empty_d     = empty_q;
    s_d         = s_q;
    n_d         = n_q;
    op_d        = op_q;
    value_d     = value_q;
    status_d    = status_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{status: cqs_pkg::ST_OK, data: '0, position: '0, last: 1'b1};
    ram_req_o   = '0;
    unique case (state_q)
      cqs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d            = in_op_i;
          value_d         = in_value_i;
          s_d             = head_q;
          n_d             = '0;
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = head_q;
          unique case (in_op_i)
            cqs_pkg::OP_INSERT: begin
              ram_req_o.wdata = in_value_i;
              if (empty_q) begin
                head_d          = '0;
                tail_d          = '0;
                empty_d         = 1'b0;
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = '0;
                status_d        = cqs_pkg::ST_OK;
              end else if (tail_nxt == head_q) begin
                status_d = cqs_pkg::ST_FULL;
              end else begin
                tail_d          = tail_nxt;
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = tail_nxt;
                status_d        = cqs_pkg::ST_OK;
              end
            end
            cqs_pkg::OP_REMOVE, cqs_pkg::OP_LIST: status_d = cqs_pkg::ST_EMPTY;
            cqs_pkg::OP_SEARCH:                   status_d = cqs_pkg::ST_NOT_FOUND;
          endcase
        end
      end
      cqs_pkg::S_RESULT: begin
        res_valid_o  = 1'b1;
        res_o.status = status_q;
      end
      cqs_pkg::S_WALK: begin
        res_valid_o = emit;
        res_o.last  = res_last;
        unique case (op_q)
          cqs_pkg::OP_REMOVE: begin
            res_o.data = ram_rdata_i;
          end
          cqs_pkg::OP_LIST: begin
            res_o.data     = ram_rdata_i;
            res_o.position = cqs_pkg::POS_W'(s_q);
          end
          cqs_pkg::OP_SEARCH: begin
            if (match) begin
              res_o.position = cqs_pkg::POS_W'(s_q);
            end else begin
              res_o.status = cqs_pkg::ST_NOT_FOUND;
            end
          end
          default: ;
        endcase
        // Step to the next slot and fetch it; hold the read data on a stall.
        if (advance) begin
          s_d             = s_nxt;
          n_d             = n_q + cqs_pkg::CAP_W'(1);
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = s_nxt;
        end
        if ((op_q == cqs_pkg::OP_REMOVE) && res_ready_i) begin
          if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else begin
            head_d = head_nxt;
          end
        end
      end
      default: ;
    endcase
    // Capacity write drops the contents.
    if (clear_i) begin
      head_d  = '0;
      tail_d  = '0;
      empty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cqs_pkg::S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    n_q      <= n_d;
    op_q     <= op_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  `CQS_ASSERT(a_empty_ptrs, empty_q |-> ((head_q == '0) && (tail_q == '0)), "empty queue with pointers off slot zero")
  `CQS_ASSERT(a_walk_bounds, (state_q == cqs_pkg::S_WALK) |-> (!empty_q && (n_q < cap_i)), "walk on empty queue or past capacity")
  `CQS_ASSERT_NEXT(a_remove_last, (state_q == cqs_pkg::S_WALK) && (op_q == cqs_pkg::OP_REMOVE) && res_ready_i && (head_q == tail_q), empty_q && (state_q == cqs_pkg::S_IDLE), "removing the only element did not empty the queue")

endmodule

// ----- hdl/circular_queue_with_search.sv -----
// ----------------------------------------------------------------------------
// circular_queue_with_search
// Ring buffer of signed 32-bit elements with insert, remove, list, search.
// ----------------------------------------------------------------------------
// Commands enter on in_i (opcode, value); results leave on out_o (status,
// data, position, last), one result per command except list on a non-empty
// queue: one result per element, oldest first, last set on the final one.
// cfg_i writes the capacity (clamped to 1 .. 16) and empties the queue;
// write it only while no command is in progress.
// One command is worked at a time. Insert, and any command on an empty
// queue, set a status that the result state puts out; remove reads the
// oldest slot and hands it out from the walk state. The next command is
// accepted once the controller is back in idle.
// List and search read one slot per cycle through the single read port of
// the slot memory while results are taken: a list puts out each stored
// element in turn, a search puts out the first match or, at the end of
// the stored run, not found.
// Results pass through an output register; when the receiver stalls, the
// walk holds on the current slot and in_i stays not ready until done.
// Reset empties the queue and sets the capacity to 16; the slot memory is
// not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_queue_with_search (
  input  logic  clk_i,
  input  logic  rst_ni,
  cqs_in_if.sink    in_i,
  cqs_out_if.source out_o,
  cqs_cfg_if.sink   cfg_i
);

  cqs_pkg::cap_t     cap_q, cap_d;
  logic              cfg_we;
  logic              out_valid_q, out_valid_d;
  cqs_pkg::res_t     out_res_q;
  logic              res_valid, res_ready;
  cqs_pkg::res_t     res;
  cqs_pkg::ram_req_t ram_req;
  logic [cqs_pkg::DATA_W-1:0] ram_rdata;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign cap_d       = cfg_we ? cqs_pkg::eff_cap(cfg_i.data) : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= cqs_pkg::CAP_W'(cqs_pkg::CAP_LIM);
    end else begin
      cap_q <= cap_d;
    end
  end

  cqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_we),
    .cap_i       (cap_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_op_i     (in_i.opcode),
    .in_value_i  (in_i.value),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (cqs_pkg::data_t'(ram_rdata))
  );

  cqs_ram #(
    .WIDTH (cqs_pkg::DATA_W),
    .DEPTH (cqs_pkg::DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: load when empty or being drained this cycle.
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_res_q.status;
  assign out_o.data     = out_res_q.data;
  assign out_o.position = out_res_q.position;
  assign out_o.last     = out_res_q.last;

endmodule

// ----- sim/circular_queue_with_search_tb.sv -----
// ----------------------------------------------------------------------------
// circular_queue_with_search_tb
// Drives insert, remove, list and search commands, plus capacity writes, with
// random gaps and stalls on both channels. A scoreboard class keeps its own
// copy of the ring and checks every result field in order.
// ----------------------------------------------------------------------------
module circular_queue_with_search_tb;
  import cqs_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned IDLE_PCT        = 29;
  localparam int unsigned PHASES          = 9;
  localparam int unsigned PHASE_ITEMS     = 49;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 20;

  class queue_scoreboard;
    data_t       slots[DEPTH];
    slot_t       oldest;
    slot_t       newest;
    bit          is_empty;
    cap_t        cap_reg;
    res_t        expected_results[$];
    int unsigned mismatches;
    int unsigned commands_seen;
    int unsigned capacity_writes;
    int unsigned longest_list;
    int unsigned status_count[4];

    function new();
      oldest   = '0;
      newest   = '0;
      is_empty = 1'b1;
      cap_reg  = cap_t'(16);
    endfunction

    // Slots in use after clamping the written capacity.
    function int unsigned ring_size();
      int unsigned c;
      c = cap_reg;
      if (c == 0) begin
        c = 1;
      end
      if (c > DEPTH) begin
        c = DEPTH;
      end
      return c;
    endfunction

    function slot_t ring_next(slot_t s);
      int unsigned n;
      n = int'(s) + 1;
      return (n >= ring_size()) ? slot_t'(0) : slot_t'(n);
    endfunction

    function void expect_result(status_e st, data_t d, slot_t p, logic l);
      res_t r;
      r.status   = st;
      r.data     = d;
      r.position = pos_t'(p);
      r.last     = l;
      expected_results.push_back(r);
    endfunction

    function void note_capacity(cap_t c);
      cap_reg  = c;
      oldest   = '0;
      newest   = '0;
      is_empty = 1'b1;
      capacity_writes++;
    endfunction

    function void note_command(op_e op, data_t v);
      slot_t       s;
      int unsigned n;
      bit          fin;
      bit          found;
      commands_seen++;
      case (op)
        OP_INSERT: begin
          if (is_empty) begin
            oldest   = '0;
            newest   = '0;
            is_empty = 1'b0;
            slots[0] = v;
            expect_result(ST_OK, '0, '0, 1'b1);
          end else if (ring_next(newest) == oldest) begin
            expect_result(ST_FULL, '0, '0, 1'b1);
          end else begin
            newest        = ring_next(newest);
            slots[newest] = v;
            expect_result(ST_OK, '0, '0, 1'b1);
          end
        end
        OP_REMOVE: begin
          if (is_empty) begin
            expect_result(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            expect_result(ST_OK, slots[oldest], '0, 1'b1);
            if (oldest == newest) begin
              oldest   = '0;
              newest   = '0;
              is_empty = 1'b1;
            end else begin
              oldest = ring_next(oldest);
            end
          end
        end
        OP_LIST: begin
          if (is_empty) begin
            expect_result(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            s = oldest;
            for (n = 0; n < ring_size(); n++) begin
              fin = (s == newest) || (n + 1 == ring_size());
              expect_result(ST_OK, slots[s], s, fin);
              if (fin) begin
                if (n + 1 > longest_list) begin
                  longest_list = n + 1;
                end
                break;
              end
              s = ring_next(s);
            end
          end
        end
        default: begin
          found = 1'b0;
          if (!is_empty) begin
            s = oldest;
            for (n = 0; n < ring_size(); n++) begin
              if (slots[s] == v) begin
                expect_result(ST_OK, '0, s, 1'b1);
                found = 1'b1;
                break;
              end
              if (s == newest) begin
                break;
              end
              s = ring_next(s);
            end
          end
          if (!found) begin
            expect_result(ST_NOT_FOUND, '0, '0, 1'b1);
          end
        end
      endcase
    endfunction

    // Random element currently held, so that searches often hit.
    function data_t pick_stored();
      slot_t       s;
      int unsigned k;
      if (is_empty) begin
        return data_t'($urandom);
      end
      s = oldest;
      k = $urandom_range(0, DEPTH - 1);
      while (k != 0 && s != newest) begin
        s = ring_next(s);
        k--;
      end
      return slots[s];
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d data %0h", got.status, got.data);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      status_count[want.status]++;
      compare_field("status", want.status, got.status);
      compare_field("data", want.data, got.data);
      compare_field("position", want.position, got.position);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cqs_in_if  in_if();
  cqs_out_if out_if();
  cqs_cfg_if cfg_if();

  circular_queue_with_search dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  queue_scoreboard sb;
  bit              tx_steady;
  bit              rx_steady;
  int unsigned     hold_off_len;
  int unsigned     cycle_count = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result(res_t'{out_if.status, out_if.data, out_if.position, out_if.last});
    end
  end

  initial begin : result_receiver
    forever begin
      @(negedge clk_i);
      if (hold_off_len != 0) begin
        // hold off long enough for the block to fill up and stall its input
        out_if.ready <= 1'b0;
        repeat (hold_off_len) @(negedge clk_i);
        hold_off_len = 0;
        out_if.ready <= 1'b1;
      end else if (rx_steady) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic op_e pick_op(bit filling);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (filling) begin
      return (r < 70) ? OP_INSERT : (r < 80) ? OP_REMOVE : (r < 88) ? OP_LIST : OP_SEARCH;
    end
    return (r < 20) ? OP_INSERT : (r < 70) ? OP_REMOVE : (r < 82) ? OP_LIST : OP_SEARCH;
  endfunction

  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      4, 5: return data_t'($urandom_range(0, 7));
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_command(op_e op, data_t val);
    @(negedge clk_i);
    while (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.value  <= val;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_command(op, val);
  endtask

  // Drop valid and wait until every outstanding result is in.
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(cap_t c);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.note_capacity(c);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    cap_t        phase_caps[PHASES];
    int unsigned p;
    int unsigned j;
    op_e         op;
    data_t       val;
    sb            = new();
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.opcode  = OP_INSERT;
    in_if.value   = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    hold_off_len  = 0;
    phase_caps    = '{5'd31, 5'd3, 5'd1, 5'd16, 5'd17, 5'd8, 5'd0, 5'd2, 5'd0};
    phase_caps[6] = cap_t'($urandom_range(0, 31));
    phase_caps[8] = cap_t'($urandom_range(0, 31));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty queue at reset capacity, then extremes and searches
    send_command(OP_REMOVE, '0);
    send_command(OP_LIST, '0);
    send_command(OP_SEARCH, 32'd5);
    send_command(OP_INSERT, 32'h8000_0000);
    send_command(OP_INSERT, 32'h7FFF_FFFF);
    send_command(OP_INSERT, '1);
    send_command(OP_INSERT, '0);
    send_command(OP_LIST, '0);
    send_command(OP_SEARCH, '1);
    send_command(OP_SEARCH, 32'd5);
    send_command(OP_SEARCH, 32'h8000_0000);
    send_command(OP_REMOVE, '0);
    send_command(OP_REMOVE, '0);

    // two slots: duplicates, full, wrap of the tail to slot zero
    drain_results();
    write_capacity(5'd2);
    send_command(OP_INSERT, 32'd7);
    send_command(OP_INSERT, 32'd7);
    send_command(OP_INSERT, 32'd9);
    send_command(OP_SEARCH, 32'd7);
    send_command(OP_REMOVE, '0);
    send_command(OP_INSERT, 32'd9);
    send_command(OP_LIST, '0);
    send_command(OP_SEARCH, 32'd9);

    // zero capacity acts as one slot
    drain_results();
    write_capacity(5'd0);
    send_command(OP_INSERT, 32'd42);
    send_command(OP_INSERT, 32'd43);
    send_command(OP_REMOVE, '0);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      write_capacity(phase_caps[p]);
      tx_steady = (p == 5);
      rx_steady = (p == 5);
      for (j = 0; j < PHASE_ITEMS; j++) begin
        if (p == 3 && j == 20) begin
          hold_off_len = HOLD_OFF_CYCLES;
        end
        // fill first, then mostly drain, so full and empty both show up
        op = pick_op(j < PHASE_ITEMS * 3 / 5);
        if (op == OP_SEARCH && $urandom_range(0, 9) < 6) begin
          val = sb.pick_stored();
        end else begin
          val = pick_value();
        end
        send_command(op, val);
      end
    end

    tx_steady = 1'b0;
    drain_results();
    rx_steady = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands over %0d capacity settings; longest list %0d elements.",
             sb.commands_seen, sb.capacity_writes, sb.longest_list);
    $display("Results by status: ok %0d, full %0d, empty %0d, not found %0d.",
             sb.status_count[ST_OK], sb.status_count[ST_FULL],
             sb.status_count[ST_EMPTY], sb.status_count[ST_NOT_FOUND]);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/cqs_pkg.sv
hdl/cqs_if.sv
hdl/cqs_ram.sv
hdl/cqs_ctrl.sv
hdl/circular_queue_with_search.sv
sim/circular_queue_with_search_tb.sv
